@@ sv/sensor_frame_crc_decoder_top_assert.svh @@
// Assertion macros for the sensor frame CRC decoder RTL.
`ifndef SENSOR_FRAME_CRC_DECODER_TOP_ASSERT_SVH
`define SENSOR_FRAME_CRC_DECODER_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SFCD_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define SFCD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/sfcd_pkg.sv @@
// Types, constants and the CRC byte update for the sensor frame CRC decoder.
package sfcd_pkg;

    localparam logic [15:0] CRC_START     = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  TEMP_MAG_MASK = 8'h7F;
    localparam logic [7:0]  TEMP_SIGN_BIT = 8'h80;

    // Frame positions: bytes 0..5 are payload, then CRC low and CRC high.
    localparam logic [2:0]  IDX_FIRST   = 3'd0;
    localparam logic [2:0]  IDX_CRC_LO  = 3'd6;
    localparam logic [2:0]  IDX_CRC_HI  = 3'd7;

    typedef struct packed {
        logic       valid;
        logic       first;
        logic [7:0] frame_byte;
    } sfcd_step_t;

    typedef struct packed {
        logic               crc_good;
        logic signed [15:0] temperature_tenths;
        logic        [15:0] humidity_tenths;
        logic        [15:0] crc_computed;
    } sfcd_result_t;

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [15:0] crc_byte_update(input logic [15:0] crc_in,
                                                    input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

@@ sv/sfcd_frame_core.sv @@
// Frame state, CRC accumulation and reading decode for one byte per cycle while step.valid is set.
module sfcd_frame_core
    import sfcd_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  sfcd_step_t   step,
    output logic         res_valid,
    output sfcd_result_t res
);

    logic [15:0]        crc_reg, crc_next;
    logic [2:0]         index_reg, index_next;
    logic [31:0]        hold_reg, hold_next;
    logic [7:0]         crc_lo_reg, crc_lo_next;
    logic signed [15:0] temp_reg, temp_next;
    logic [15:0]        hum_reg, hum_next;

    logic [2:0]   idx;
    logic [15:0]  crc_base;
    logic [15:0]  received;
    logic         good;
    logic [7:0]   t_hi_mag;
    logic [15:0]  mag;
    logic         t_neg;

    assign idx      = step.first ? IDX_FIRST : index_reg;
    assign crc_base = (idx == IDX_FIRST) ? CRC_START : crc_reg;
    assign received = {step.frame_byte, crc_lo_reg};
    assign good     = (received == crc_reg);
    assign t_hi_mag = hold_reg[15:8] & TEMP_MAG_MASK;
    assign t_neg    = |(hold_reg[15:8] & TEMP_SIGN_BIT);
    assign mag      = {t_hi_mag, hold_reg[7:0]};

    always_comb begin
        crc_next    = crc_reg;
        index_next  = index_reg;
        hold_next   = hold_reg;
        crc_lo_next = crc_lo_reg;
        temp_next   = temp_reg;
        hum_next    = hum_reg;
        res_valid   = 1'b0;
        if (step.valid) begin
            if (idx < IDX_CRC_LO) begin
                crc_next   = crc_byte_update(crc_base, step.frame_byte);
                hold_next  = {hold_reg[23:0], step.frame_byte};
                index_next = idx + 3'd1;
            end else if (idx == IDX_CRC_LO) begin
                crc_lo_next = step.frame_byte;
                index_next  = idx + 3'd1;
            end else begin
                res_valid  = 1'b1;
                index_next = IDX_FIRST;
                if (good) begin
                    hum_next  = hold_reg[31:16];
                    // sign-magnitude to two's complement; negative zero folds to 0
                    temp_next = t_neg ? $signed(16'h0000 - mag) : $signed(mag);
                end
            end
        end
    end

    assign res.crc_good           = good;
    assign res.temperature_tenths = temp_next;
    assign res.humidity_tenths    = hum_next;
    assign res.crc_computed       = crc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= CRC_START;
            index_reg  <= IDX_FIRST;
            hold_reg   <= '0;
            crc_lo_reg <= '0;
            temp_reg   <= '0;
            hum_reg    <= '0;
        end else begin
            crc_reg    <= crc_next;
            index_reg  <= index_next;
            hold_reg   <= hold_next;
            crc_lo_reg <= crc_lo_next;
            temp_reg   <= temp_next;
            hum_reg    <= hum_next;
        end
    end

`include "sensor_frame_crc_decoder_top_assert.svh"

    `SFCD_ASSERT_NEXT(a_first_advances, aclk, aresetn, step.valid && step.first, index_reg == 3'd1, "frame start did not move the byte count to one")
    `SFCD_ASSERT_NEXT(a_result_wraps, aclk, aresetn, res_valid, index_reg == IDX_FIRST, "byte count did not wrap after a result")
    `SFCD_ASSERT_NEXT(a_idle_holds, aclk, aresetn, !step.valid, $stable(crc_reg) && $stable(index_reg) && $stable(temp_reg), "frame state moved without a byte")
    `SFCD_ASSERT_IMPL(a_result_on_crc_hi, aclk, aresetn, res_valid, step.valid && !step.first && index_reg == IDX_CRC_HI, "result emitted off the CRC high byte")

endmodule

@@ sv/sensor_frame_crc_decoder_top.sv @@
// Top level of the sensor frame CRC decoder: input stage, frame core, result register.
//
//   channel | dir | tdata (low bit up)                              | tuser
//   s_      | in  | frame_byte[7:0]                                 | frame_first
//   m_      | out | temperature_tenths, humidity_tenths, crc_computed | crc_good
//
// One byte per cycle sustained while m_ is not stalled; a result passes from the eighth
// byte's transaction through the input register, then the result register.
// The CRC of one byte is an unrolled eight-step update between the registers.
// Reset (aresetn low, synchronous) empties both stages and restarts the frame count.
// A stall on m_ holds the result register; the input stage then fills and
// s_tready drops until the result is taken.
module sensor_frame_crc_decoder_top
    import sfcd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // frame_byte[7:0]
    input  logic        s_tuser,   // frame_first
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // temperature_tenths[15:0], humidity_tenths[31:16],
                                   // crc_computed[47:32]
    output logic        m_tuser    // crc_good
);

    logic         in_valid_reg;
    logic         in_first_reg;
    logic [7:0]   in_byte_reg;
    logic         out_valid_reg;
    sfcd_result_t out_reg;

    logic         advance;
    sfcd_step_t   step;
    logic         res_valid;
    sfcd_result_t res;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign step.valid      = advance;
    assign step.first      = in_first_reg;
    assign step.frame_byte = in_byte_reg;

    sfcd_frame_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.crc_good;
    assign m_tdata  = {out_reg.crc_computed, out_reg.humidity_tenths,
                       out_reg.temperature_tenths};

endmodule
